### sv/mawf_pkg.sv
`default_nettype none
package mawf_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_ctrl;

endpackage
`default_nettype wire

### sv/mawf_ram.sv
`default_nettype none
module mawf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### sv/mawf_div.sv
`default_nettype none
module mawf_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]         i_den,
    output mawf_pkg::t_div_ctrl           o_ctrl,
    output logic signed [NUM_W-1:0]       o_quot
);

    import mawf_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [NUM_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;

    logic [DEN_W:0]   shifted;
    logic             q_bit;
    logic [DEN_W:0]   diff;

    always_comb begin
        shifted = {r_rem, r_dvd[NUM_W-1]};
        q_bit   = (shifted >= {1'b0, r_den});
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == CNT_W'(1)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_dvd <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_ctrl.busy = r_busy;
    assign o_ctrl.done = r_done;
    assign o_quot      = r_neg ? NUM_W'(-r_dvd) : NUM_W'(r_dvd);

endmodule
`default_nettype wire

### sv/moving_average_warmup_filter_core.sv
`default_nettype none
// Moving average over the last WINDOW signed samples, with warm-up: until the
// window has filled, each result is the mean of the samples seen so far,
// truncated toward zero. One transaction is in work at a time. The result is
// offered once the READ state has read the RAM and started the divider, and
// the one-bit-per-cycle divider has finished in DIV; o_stall is high from
// acceptance until the result is loaded, so no new sample is taken till then.
// The sample ring sits in a RAM with registered read, and a running total
// is kept so only the overwritten entry is read back. A finished result
// waits in the output register while the next sample is taken.
module moving_average_warmup_filter_core #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_average
);

    import mawf_pkg::*;

    localparam int TW = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]                    r_state;
    logic [SW-1:0]                 r_slot;
    logic [CW-1:0]                 r_fill;
    logic signed [TW-1:0]          r_total;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_average;

    logic                          accept;
    logic                          full;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic signed [TW-1:0]          old_ext;
    logic signed [TW-1:0]          n_total;
    logic [CW-1:0]                 n_fill;
    logic [SW-1:0]                 n_slot;
    logic                          div_start;
    t_div_ctrl                     div_ctrl;
    logic signed [TW-1:0]          div_quot;
    logic                          out_load;

    assign accept    = i_valid && !o_stall;
    assign full      = (r_fill == CW'(WINDOW));
    assign div_start = (r_state == ST_READ);
    assign out_load  = (r_state == ST_DIV) && div_ctrl.done && (!r_out_valid || !i_stall);

    always_comb begin
        old_ext = full ? TW'(signed'(rd_data)) : '0;
        n_total = r_total - old_ext + TW'(r_sample);
        n_fill  = full ? r_fill : r_fill + CW'(1);
        n_slot  = (r_slot == SW'(WINDOW - 1)) ? '0 : r_slot + SW'(1);
    end

    mawf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (div_start),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_re    (accept),
        .i_raddr (r_slot),
        .o_rdata (rd_data)
    );

    mawf_div #(
        .NUM_W (TW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_total),
        .i_den   (n_fill),
        .o_ctrl  (div_ctrl),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_total <= n_total;
                    r_fill  <= n_fill;
                    r_slot  <= n_slot;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
        if (out_load) begin
            r_average <= div_quot[SAMPLE_BITS-1:0];
        end
    end

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_average = r_average;

endmodule
`default_nettype wire

### sv/mawf_check.sv
`default_nettype none
module mawf_check #(
    parameter int SAMPLE_BITS = 24
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic signed [SAMPLE_BITS-1:0] o_average
);

    // A stalled result transaction keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_average))
        else $error("result changed while stalled");

    // Only one sample transaction is in work at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second sample taken while one is in work");

    // A new result only appears at the end of a busy period.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a sample in work");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

bind moving_average_warmup_filter_core mawf_check #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mawf_check (.*);
`default_nettype wire
